// ===== sv/hft_pkg.sv =====
// ============================================================================
// hft_pkg - shared types and constants of the Helmert frame transform
// Point and item types, register indexes, axis pairing and saturation helper.
// ============================================================================
package hft_pkg;

    typedef logic signed [47:0] coord_t;
    typedef logic signed [48:0] diff_t;
    typedef logic signed [99:0] acc_t;

    // item leaving the front: direction and (point, or point minus translation)
    typedef struct packed {
        logic         act;
        diff_t [2:0]  d;
    } qitem_t;

    // item travelling down the arithmetic pipeline
    typedef struct packed {
        logic         act;
        coord_t [2:0] v;
    } pitem_t;

    localparam logic ACT_FORWARD = 1'b0;
    localparam logic ACT_INVERSE = 1'b1;

    localparam logic [2:0] REG_ROT_X     = 3'd0;
    localparam logic [2:0] REG_ROT_Y     = 3'd1;
    localparam logic [2:0] REG_ROT_Z     = 3'd2;
    localparam logic [2:0] REG_SCALE     = 3'd3;
    localparam logic [2:0] REG_INV_SCALE = 3'd4;
    localparam logic [2:0] REG_SHIFT_X   = 3'd5;
    localparam logic [2:0] REG_SHIFT_Y   = 3'd6;
    localparam logic [2:0] REG_SHIFT_Z   = 3'd7;

    localparam logic [63:0] ROT_RESET   = 64'h0000_0000_4000_0000;
    localparam logic [47:0] SCALE_RESET = 48'h4000_0000_0000;

    // axes touched by each rotation: x acts on (y,z), y on (z,x), z on (x,y)
    localparam logic [1:0] PAIR_AXES [0:3] = '{2'd1, 2'd2, 2'd0, 2'd1};

    localparam acc_t SAT_HI = 100'sh7FFF_FFFF_FFFF;
    localparam acc_t SAT_LO = -100'sh8000_0000_0000;

    // clamp a wide signed value to the 48-bit coordinate range
    function automatic coord_t sat48(input acc_t w);
        coord_t r;
        if (w > SAT_HI)
            r = SAT_HI[47:0];
        else if (w < SAT_LO)
            r = SAT_LO[47:0];
        else
            r = w[47:0];
        return r;
    endfunction

    // rotation used by pipeline slot k: x, y, z forward; z, y, x inverse
    function automatic logic [1:0] rot_sel(input logic act, input logic [1:0] slot);
        logic [1:0] r;
        if (act == ACT_INVERSE)
            r = 2'd2 - slot;
        else
            r = slot;
        return r;
    endfunction

endpackage

// ===== sv/helmert_frame_transform.sv =====
// ============================================================================
// helmert_frame_transform - seven-parameter frame transform, fixed point
// Carries a Cartesian point forward into or back out of the standard frame.
//
//   port group  dir  contents
//   s_*         in   item: tuser action, tdata in_x, in_y, in_z
//   m_*         out  item: tdata out_x, out_y, out_z
//   cfg_*       in   register write, index and data
//
// One item per cycle while the output does not stall. An item goes from the
// front register into the queue and then through the arithmetic stages
// (two per scaling unit, two per rotation unit) to m_tvalid.
// Reset clears control only; the registers return to cosine 0 and sine 1.0
// for each rotation, unit scale and zero translation.
// An output stall freezes the arithmetic pipe; the two-entry queue and the
// front register keep taking items until they fill.
// ============================================================================
module helmert_frame_transform
    import hft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // in_x [47:0], in_y [95:48], in_z [143:96]
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,   // out_x [47:0], out_y [95:48], out_z [143:96]
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic [2:0][63:0] rot_reg;
    logic [47:0]      scale_reg;
    logic [47:0]      inv_scale_reg;
    coord_t [2:0]     shift_reg;

    logic   push;
    qitem_t push_item;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    qitem_t q_item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg       <= {ROT_RESET, ROT_RESET, ROT_RESET};
            scale_reg     <= SCALE_RESET;
            inv_scale_reg <= SCALE_RESET;
            shift_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_X:     rot_reg[0]    <= cfg_data;
                REG_ROT_Y:     rot_reg[1]    <= cfg_data;
                REG_ROT_Z:     rot_reg[2]    <= cfg_data;
                REG_SCALE:     scale_reg     <= cfg_data[47:0];
                REG_INV_SCALE: inv_scale_reg <= cfg_data[47:0];
                REG_SHIFT_X:   shift_reg[0]  <= cfg_data[47:0];
                REG_SHIFT_Y:   shift_reg[1]  <= cfg_data[47:0];
                REG_SHIFT_Z:   shift_reg[2]  <= cfg_data[47:0];
                default:       ;
            endcase
        end
    end

    hft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .shift     (shift_reg),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    hft_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    hft_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .rots      (rot_reg),
        .scale     (scale_reg),
        .inv_scale (inv_scale_reg),
        .shift     (shift_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== sv/hft_front.sv =====
// ============================================================================
// hft_front - input stage of the Helmert frame transform
// Accepts items, classifies the direction and removes the translation for
// inverse items before handing them to the queue.
// ============================================================================
module hft_front
    import hft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         s_tuser,
    input  coord_t [2:0] shift,
    output logic         push,
    output qitem_t       push_item,
    input  logic         q_full
);

    logic   vld_reg;
    qitem_t item_reg;
    qitem_t item_next;
    logic   accept;

    assign s_tready  = !vld_reg || !q_full;
    assign accept    = s_tvalid && s_tready;
    assign push      = vld_reg && !q_full;
    assign push_item = item_reg;

    // classify: inverse items lose the translation here, kept exact at 49 bits
    always_comb
    begin
        item_next.act = s_tuser;
        for (int i = 0; i < 3; i++)
        begin
            if (s_tuser == ACT_INVERSE)
                item_next.d[i] = 49'($signed(s_tdata[48*i +: 48]))
                               - 49'($signed(shift[i]));
            else
                item_next.d[i] = 49'($signed(s_tdata[48*i +: 48]));
        end
    end

    // hold the item until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (accept)
            vld_reg <= 1'b1;
        else if (push)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

// ===== sv/hft_queue.sv =====
// ============================================================================
// hft_queue - two-entry queue between front and back
// Lets the front keep accepting while the back stalls on its output.
// ============================================================================
module hft_queue
    import hft_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  qitem_t push_item,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output qitem_t pop_item
);

    qitem_t     mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign valid    = (cnt_reg != 2'd0);
    assign pop_item = mem_reg[rp_reg];

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_item;
    end

endmodule

// ===== sv/hft_rot.sv =====
// ============================================================================
// hft_rot - one plane rotation, two pipeline stages
// Stage one forms the split partial products, stage two sums, rounds half up
// at 30 fraction bits and saturates both rotated coordinates.
// ============================================================================
module hft_rot
    import hft_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  pitem_t      in_item,
    input  logic [63:0] rot_cs,
    input  logic [1:0]  pa,
    input  logic [1:0]  qa,
    output pitem_t      out_item
);

    localparam logic signed [89:0] RND30 = 90'sh2000_0000;

    logic signed [31:0] c;
    logic signed [31:0] s;
    logic signed [32:0] c33;
    logic signed [32:0] sf;
    logic signed [32:0] nsf;
    coord_t             a;
    coord_t             b;
    logic signed [23:0] ah;
    logic signed [23:0] bh;
    logic signed [24:0] al;
    logic signed [24:0] bl;

    logic signed [57:0] p_ah_reg, p_al_reg, p_bh_reg, p_bl_reg;
    logic signed [57:0] q_bh_reg, q_bl_reg, q_ah_reg, q_al_reg;
    pitem_t             item_reg;
    logic [1:0]         pa_reg;
    logic [1:0]         qa_reg;

    logic signed [89:0] sum_p;
    logic signed [89:0] sum_q;
    pitem_t             res;

    // split operands; the sine changes sign for inverse items
    always_comb
    begin
        c   = rot_cs[63:32];
        s   = rot_cs[31:0];
        c33 = 33'(c);
        sf  = (in_item.act == ACT_INVERSE) ? -33'(s) : 33'(s);
        nsf = -sf;
        a   = in_item.v[pa];
        b   = in_item.v[qa];
        ah  = a[47:24];
        bh  = b[47:24];
        al  = $signed({1'b0, a[23:0]});
        bl  = $signed({1'b0, b[23:0]});
    end

    // register partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ah_reg <= ah * c33;
            p_al_reg <= al * c33;
            p_bh_reg <= bh * sf;
            p_bl_reg <= bl * sf;
            q_bh_reg <= bh * c33;
            q_bl_reg <= bl * c33;
            q_ah_reg <= ah * nsf;
            q_al_reg <= al * nsf;
            item_reg <= in_item;
            pa_reg   <= pa;
            qa_reg   <= qa;
        end
    end

    // sum, round and write the pair back
    always_comb
    begin
        sum_p = ((90'(p_ah_reg) + 90'(p_bh_reg)) <<< 24)
              + 90'(p_al_reg) + 90'(p_bl_reg) + RND30;
        sum_q = ((90'(q_bh_reg) + 90'(q_ah_reg)) <<< 24)
              + 90'(q_bl_reg) + 90'(q_al_reg) + RND30;
        res           = item_reg;
        res.v[pa_reg] = sat48(100'(sum_p >>> 30));
        res.v[qa_reg] = sat48(100'(sum_q >>> 30));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item <= res;
    end

endmodule

// ===== sv/hft_scale.sv =====
// ============================================================================
// hft_scale - scaling of all three coordinates, two pipeline stages
// Multiplies by a 46-fraction-bit factor in 24-bit pieces, rounds half up,
// adds an offset and saturates; items that skip scaling pass unchanged.
// ============================================================================
module hft_scale
    import hft_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  logic         act,
    input  logic         apply,
    input  diff_t [2:0]  d,
    input  logic [47:0]  factor,
    input  coord_t [2:0] addend,
    output pitem_t       out_item
);

    localparam acc_t RND46 = 100'sh2000_0000_0000;

    logic signed [24:0] sh;
    logic signed [24:0] sl;

    logic signed [49:0] p0_reg  [3];
    logic signed [49:0] p1a_reg [3];
    logic signed [49:0] p1b_reg [3];
    logic signed [49:0] p2_reg  [3];
    coord_t             byp_reg [3];
    coord_t             add_reg [3];
    logic               apply_reg;
    logic               act_reg;

    acc_t   tot [3];
    pitem_t res;

    assign sh = $signed({1'b0, factor[47:24]});
    assign sl = $signed({1'b0, factor[23:0]});

    // form partial products per axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p0_reg[i]  <= $signed({1'b0, d[i][23:0]}) * sl;
                p1a_reg[i] <= $signed(d[i][48:24]) * sl;
                p1b_reg[i] <= $signed({1'b0, d[i][23:0]}) * sh;
                p2_reg[i]  <= $signed(d[i][48:24]) * sh;
                byp_reg[i] <= d[i][47:0];
                add_reg[i] <= addend[i];
            end
            apply_reg <= apply;
            act_reg   <= act;
        end
    end

    // combine, round, offset and clamp
    always_comb
    begin
        res.act = act_reg;
        for (int i = 0; i < 3; i++)
        begin
            tot[i] = (100'(p2_reg[i]) <<< 48)
                   + ((100'(p1a_reg[i]) + 100'(p1b_reg[i])) <<< 24)
                   + 100'(p0_reg[i]) + RND46;
            if (apply_reg)
                res.v[i] = sat48((tot[i] >>> 46) + 100'(add_reg[i]));
            else
                res.v[i] = byp_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_item <= res;
    end

endmodule

// ===== sv/hft_back.sv =====
// ============================================================================
// hft_back - arithmetic pipeline of the Helmert frame transform
// Inverse scale, three rotation slots, forward scale with translation; each
// rotation slot works on every item; a scale unit skips the other direction.
// ============================================================================
module hft_back
    import hft_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  qitem_t             q_item,
    output logic               pop,
    input  logic [2:0][63:0]   rots,
    input  logic [47:0]        scale,
    input  logic [47:0]        inv_scale,
    input  coord_t [2:0]       shift,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [143:0]       m_tdata
);

    localparam int LAT = 10;

    logic [LAT-1:0] vld_reg;
    logic           en;
    pitem_t         stg [4];
    pitem_t         last;
    logic [1:0]     ridx [3];
    diff_t [2:0]    fwd_d;
    coord_t [2:0]   zero_add;

    // stall the whole pipe only while a result waits on the output
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign pop      = en && q_valid;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {last.v[2], last.v[1], last.v[0]};
    assign zero_add = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], q_valid};
    end

    // inverse items are scaled first
    hft_scale u_scale_inv (
        .clk      (clk),
        .en       (en),
        .act      (q_item.act),
        .apply    (q_item.act == ACT_INVERSE),
        .d        (q_item.d),
        .factor   (inv_scale),
        .addend   (zero_add),
        .out_item (stg[0])
    );

    // rotation slots
    for (genvar k = 0; k < 3; k++)
    begin : g_rot
        assign ridx[k] = rot_sel(stg[k].act, 2'(k));
        hft_rot u_rot (
            .clk      (clk),
            .en       (en),
            .in_item  (stg[k]),
            .rot_cs   (rots[ridx[k]]),
            .pa       (PAIR_AXES[ridx[k]]),
            .qa       (PAIR_AXES[ridx[k] + 2'd1]),
            .out_item (stg[k+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            fwd_d[i] = 49'(stg[3].v[i]);
    end

    // forward items are scaled and translated last
    hft_scale u_scale_fwd (
        .clk      (clk),
        .en       (en),
        .act      (stg[3].act),
        .apply    (stg[3].act == ACT_FORWARD),
        .d        (fwd_d),
        .factor   (scale),
        .addend   (shift),
        .out_item (last)
    );

endmodule
